// File: hdl/gks_pkg.sv
package gks_pkg;

	// Field widths fixed by the interface
	localparam int COORD_W    = 16;
	localparam int DIM_W      = 11;
	localparam int CELL_OUT_W = 8;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;

	// Parameter defaults
	localparam int MAX_GRID_DIM_DEF = 256;
	localparam int CELL_PIXELS_DEF  = 10;
	localparam int FRAC_BITS_DEF    = 4;

	// Occupancy memory word; one clear-sweep step covers one word
	localparam int MEM_WORD_W = 64;

	// Register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd1;
	localparam logic [DIM_W-1:0]     IMAGE_ROWS_RST = 11'd480;
	localparam logic [DIM_W-1:0]     IMAGE_COLS_RST = 11'd640;

	// Opcodes
	localparam logic OP_POINT = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_KEPT  = 2'd0,
		STATUS_OOB   = 2'd1,
		STATUS_OCC   = 2'd2,
		STATUS_FRAME = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic calc;
		logic check;
		logic emit;
		logic emit_frame;
		logic clr_en;
	} gks_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
	} gks_sts_t;

endpackage

// File: hdl/gks_ctrl.sv
module gks_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_opcode,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  gks_pkg::gks_sts_t sts,
	output gks_pkg::gks_cmd_t cmd
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q, state_d;
	logic       frame_q;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;
	logic       emit;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign slot_free = ~out_valid_q | out_ready;
	assign emit      = (state_q == ST_EMIT) & slot_free;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (sts.clr_last)
					state_d = frame_q ? ST_EMIT : ST_IDLE;
			end
			ST_IDLE: begin
				if (accept)
					state_d = (in_opcode == gks_pkg::OP_FRAME) ? ST_CLR : ST_CALC;
			end
			ST_CALC: state_d = ST_CHK;
			ST_CHK:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture    = accept;
		cmd.calc       = (state_q == ST_CALC);
		cmd.check      = (state_q == ST_CHK);
		cmd.emit       = emit;
		cmd.emit_frame = frame_q;
		cmd.clr_en     = (state_q == ST_CLR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			frame_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && in_opcode == gks_pkg::OP_FRAME)
				frame_q <= 1'b1;
			else if (emit)
				frame_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// a new word only appears from the emit state
	a_word_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result word raised outside emit");

	// a keypoint runs calc then check before it can emit
	a_point_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_opcode == gks_pkg::OP_POINT |=> state_q == ST_CALC ##1 state_q == ST_CHK)
		else $error("keypoint sequence broken");

	// the clear sweep runs to its last word without a break
	a_sweep_whole: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR && !sts.clr_last |=> state_q == ST_CLR)
		else $error("clear sweep cut short");

	// frame result only after a full sweep
	a_frame_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) && frame_q |-> $past(sts.clr_last))
		else $error("frame result before sweep end");

endmodule

// File: hdl/gks_dpath.sv
module gks_dpath #(
	parameter int MAX_GRID_DIM = gks_pkg::MAX_GRID_DIM_DEF,
	parameter int CELL_PIXELS  = gks_pkg::CELL_PIXELS_DEF,
	parameter int FRAC_BITS    = gks_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gks_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gks_pkg::DIM_W-1:0]           cfg_data,
	input  logic [gks_pkg::COORD_W-1:0]         point_x,
	input  logic [gks_pkg::COORD_W-1:0]         point_y,
	input  gks_pkg::gks_cmd_t                   cmd,
	output gks_pkg::gks_sts_t                   sts,
	output logic                                keep,
	output gks_pkg::status_t                    status,
	output logic [gks_pkg::CELL_OUT_W-1:0]      cell_x,
	output logic [gks_pkg::CELL_OUT_W-1:0]      cell_y
);

	localparam int CW     = gks_pkg::COORD_W;
	localparam int DW     = gks_pkg::DIM_W;
	localparam int OW     = gks_pkg::CELL_OUT_W;
	// cell index bits per axis; rows are strided by a power of two
	localparam int GW     = $clog2(MAX_GRID_DIM);
	localparam int WW     = gks_pkg::MEM_WORD_W;
	localparam int BW     = $clog2(WW);
	localparam int AW     = 2 * GW - BW;
	localparam int DEPTH  = 1 << AW;
	// reciprocal of CELL_PIXELS; exact for 11-bit dividends as 2047*63 < 2^18
	localparam int RSH    = DW + 7;
	localparam int RMUL   = ((1 << RSH) + CELL_PIXELS - 1) / CELL_PIXELS;
	localparam int PW     = DW + RSH;

	localparam logic [CW-1:0] ONE_PX  = CW'(1) << FRAC_BITS;
	localparam logic [DW-1:0] MAX_DIM = DW'(MAX_GRID_DIM);

	// configuration
	logic [DW-1:0] rows_q, cols_q;
	logic [DW-1:0] gw_q, gh_q;
	logic [PW-1:0] gw_prod, gh_prod;
	logic [DW-1:0] gw_quo, gh_quo;

	// captured point
	logic [CW-1:0] x_q, y_q;

	// calc stage
	logic [CW-1:0] pxf, pyf;
	logic          x_neg, y_neg;
	logic          x_nok, y_nok;
	logic [DW-1:0] px, py;
	logic          pok_x_s1, pok_y_s1;
	logic [PW-1:0] prod_x_s1, prod_y_s1;

	// check stage
	logic [DW-1:0] cx, cy;
	logic [2*GW-1:0] idx;
	logic          inb_s2;
	logic [DW-1:0] cx_s2, cy_s2;
	logic [AW-1:0] word_s2;
	logic [BW-1:0] bit_s2;

	// memory
	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rd_data_q;
	logic [AW-1:0] clr_addr_q;
	logic          occupied;
	logic          mark;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [WW-1:0] wr_data;

	// output word
	logic                keep_q;
	gks_pkg::status_t    status_q;
	logic [OW-1:0]       cell_x_q, cell_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gks_pkg::IMAGE_ROWS_RST;
			cols_q <= gks_pkg::IMAGE_COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gks_pkg::REG_IMAGE_ROWS: rows_q <= cfg_data;
				gks_pkg::REG_IMAGE_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// grid size, saturated
	always_comb begin
		gw_prod = PW'(cols_q) * PW'(RMUL);
		gh_prod = PW'(rows_q) * PW'(RMUL);
		gw_quo  = gw_prod[RSH +: DW];
		gh_quo  = gh_prod[RSH +: DW];
	end

	always_ff @(posedge clk) begin
		gw_q <= (gw_quo > MAX_DIM) ? MAX_DIM : gw_quo;
		gh_q <= (gh_quo > MAX_DIM) ? MAX_DIM : gh_quo;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q <= point_x;
			y_q <= point_y;
		end
	end

	// pixel truncation toward zero: (-1,0) px maps to 0, anything lower is out
	always_comb begin
		x_neg = x_q[CW-1];
		y_neg = y_q[CW-1];
		x_nok = x_neg & ~($signed(x_q) > -$signed(ONE_PX));
		y_nok = y_neg & ~($signed(y_q) > -$signed(ONE_PX));
		pxf   = x_q >> FRAC_BITS;
		pyf   = y_q >> FRAC_BITS;
		px    = x_neg ? '0 : pxf[DW-1:0];
		py    = y_neg ? '0 : pyf[DW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			pok_x_s1  <= ~x_nok & (x_neg | ~(|pxf[CW-1:DW])) & (px < cols_q);
			pok_y_s1  <= ~y_nok & (y_neg | ~(|pyf[CW-1:DW])) & (py < rows_q);
			prod_x_s1 <= PW'(px) * PW'(RMUL);
			prod_y_s1 <= PW'(py) * PW'(RMUL);
		end
	end

	always_comb begin
		cx  = prod_x_s1[RSH +: DW];
		cy  = prod_y_s1[RSH +: DW];
		idx = {cy[GW-1:0], cx[GW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			inb_s2    <= pok_x_s1 & pok_y_s1 & (cx < gw_q) & (cy < gh_q);
			cx_s2     <= cx;
			cy_s2     <= cy;
			word_s2   <= idx[2*GW-1:BW];
			bit_s2    <= idx[BW-1:0];
			rd_data_q <= mem[idx[2*GW-1:BW]];
		end
	end

	assign occupied = rd_data_q[bit_s2];
	assign mark     = cmd.emit & ~cmd.emit_frame & inb_s2 & ~occupied;

	always_comb begin
		wr_en   = cmd.clr_en | mark;
		wr_addr = cmd.clr_en ? clr_addr_q : word_s2;
		wr_data = cmd.clr_en ? '0 : (rd_data_q | (WW'(1) << bit_s2));
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (cmd.clr_en)
			clr_addr_q <= clr_addr_q + AW'(1);
	end

	assign sts.clr_last = (clr_addr_q == AW'(DEPTH - 1));

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			priority if (cmd.emit_frame) begin
				keep_q   <= 1'b0;
				status_q <= gks_pkg::STATUS_FRAME;
				cell_x_q <= '0;
				cell_y_q <= '0;
			end else if (!inb_s2) begin
				keep_q   <= 1'b0;
				status_q <= gks_pkg::STATUS_OOB;
				cell_x_q <= '0;
				cell_y_q <= '0;
			end else if (occupied) begin
				keep_q   <= 1'b0;
				status_q <= gks_pkg::STATUS_OCC;
				cell_x_q <= cx_s2[OW-1:0];
				cell_y_q <= cy_s2[OW-1:0];
			end else begin
				keep_q   <= 1'b1;
				status_q <= gks_pkg::STATUS_KEPT;
				cell_x_q <= cx_s2[OW-1:0];
				cell_y_q <= cy_s2[OW-1:0];
			end
		end
	end

	assign keep   = keep_q;
	assign status = status_q;
	assign cell_x = cell_x_q;
	assign cell_y = cell_y_q;

	// a mark only lands on an in-bounds cell
	a_mark_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		mark |-> inb_s2 && cx_s2 < gw_q && cy_s2 < gh_q)
		else $error("mark outside grid");

	// sweep and mark never share the write port
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_en && cmd.emit))
		else $error("sweep and emit overlap");

	// a kept word follows a mark of that cell
	a_keep_marks: assert property (@(posedge clk) disable iff (!arst_n)
		mark |=> keep_q && status_q == gks_pkg::STATUS_KEPT)
		else $error("mark without kept word");

endmodule

// File: hdl/grid_keypoint_suppressor_core.sv
// channel   | handshake            | word
// ----------+----------------------+--------------------------------------
// input     | in_valid / in_ready  | opcode, point_x, point_y
// result    | out_valid / out_ready| keep, status, cell_x, cell_y
// config    | cfg_we (no wait)     | cfg_index, cfg_data
//
// Keypoint word: accept, scale, map read, then map update with the result; the next word
// is taken only once the result is registered, and that step waits while a result is held.
// Frame word: one map word cleared per cycle, MAX_GRID_DIM^2/64 words
// (1024 at defaults), then the result; input is held off meanwhile.
// Reset: async, active low; after release the same sweep clears the map first.
// Stalls: a waiting result does not hold off the next input word, only the next result.
module grid_keypoint_suppressor_core #(
	parameter int MAX_GRID_DIM = gks_pkg::MAX_GRID_DIM_DEF,
	parameter int CELL_PIXELS  = gks_pkg::CELL_PIXELS_DEF,
	parameter int FRAC_BITS    = gks_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [gks_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gks_pkg::DIM_W-1:0]         cfg_data,
	// input words
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [gks_pkg::COORD_W-1:0]       point_x,
	input  logic [gks_pkg::COORD_W-1:0]       point_y,
	// result words
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              keep,
	output logic [gks_pkg::STATUS_W-1:0]      status,
	output logic [gks_pkg::CELL_OUT_W-1:0]    cell_x,
	output logic [gks_pkg::CELL_OUT_W-1:0]    cell_y
);

	gks_pkg::gks_cmd_t cmd;
	gks_pkg::gks_sts_t sts;
	gks_pkg::status_t  status_w;

	// sequencing: sweep, accept, scale, read, update/emit
	gks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (opcode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// config registers, coordinate scaling, bounds, occupancy map, result reg
	gks_dpath #(
		.MAX_GRID_DIM (MAX_GRID_DIM),
		.CELL_PIXELS  (CELL_PIXELS),
		.FRAC_BITS    (FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.point_x   (point_x),
		.point_y   (point_y),
		.cmd       (cmd),
		.sts       (sts),
		.keep      (keep),
		.status    (status_w),
		.cell_x    (cell_x),
		.cell_y    (cell_y)
	);

	assign status = status_w;

endmodule

// File: tb/grid_keypoint_suppressor_core_tb.sv
`timescale 1ns / 1ps

module grid_keypoint_suppressor_core_tb;

	// A local predictor mirrors the occupancy map and both image size registers,
	// works out the result for every input word at acceptance and queues it.
	// The result side pops the oldest entry for each accepted result word and
	// compares it field by field.

	localparam int MAX_GRID      = gks_pkg::MAX_GRID_DIM_DEF;
	localparam int CELL_PX       = gks_pkg::CELL_PIXELS_DEF;
	localparam int SUB_PER_PX    = 1 << gks_pkg::FRAC_BITS_DEF;
	localparam int SUB_PER_CELL  = CELL_PX * SUB_PER_PX;
	// Longest quiet stretch is a map clear (MAX_GRID^2/64 words) plus
	// stalls; several times that before we give up.
	localparam int QUIET_LIMIT   = 5 * (MAX_GRID * MAX_GRID / gks_pkg::MEM_WORD_W);
	// Leave a margin after the last result before touching registers
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic                           keep;
		gks_pkg::status_t               status;
		logic [gks_pkg::CELL_OUT_W-1:0] cell_x;
		logic [gks_pkg::CELL_OUT_W-1:0] cell_y;
	} verdict_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [gks_pkg::CFG_IDX_W-1:0]  cfg_index = gks_pkg::REG_IMAGE_ROWS;
	logic [gks_pkg::DIM_W-1:0]      cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic                           opcode    = gks_pkg::OP_POINT;
	logic [gks_pkg::COORD_W-1:0]    point_x   = '0;
	logic [gks_pkg::COORD_W-1:0]    point_y   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           keep;
	logic [gks_pkg::STATUS_W-1:0]   status;
	logic [gks_pkg::CELL_OUT_W-1:0] cell_x;
	logic [gks_pkg::CELL_OUT_W-1:0] cell_y;

	// Predictor state: one mark per cell, row-major on the full grid
	bit                        cell_marked [MAX_GRID * MAX_GRID];
	logic [gks_pkg::DIM_W-1:0] rows_now = gks_pkg::IMAGE_ROWS_RST;
	logic [gks_pkg::DIM_W-1:0] cols_now = gks_pkg::IMAGE_COLS_RST;

	verdict_t pending_verdicts [$];
	int       n_errors   = 0;
	int       quiet_cyc  = 0;
	// Cleared for stretches where neither side inserts gaps
	bit       idle_on    = 1'b1;

	grid_keypoint_suppressor_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.point_x   (point_x),
		.point_y   (point_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.keep      (keep),
		.status    (status),
		.cell_x    (cell_x),
		.cell_y    (cell_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Grid extent along one axis: whole cells only, saturating at the map size
	function automatic int grid_span(logic [gks_pkg::DIM_W-1:0] pixels);
		int g;
		g = int'(pixels) / CELL_PX;
		if (g > MAX_GRID)
			g = MAX_GRID;
		return g;
	endfunction

	// Works out the result of one input word and updates the mirrored map.
	// SV integer division truncates toward zero, as the block does, so a
	// coordinate just below zero (under one pixel) lands in pixel 0, cell 0.
	function automatic verdict_t suppress_point(logic op, logic [gks_pkg::COORD_W-1:0] x,
			logic [gks_pkg::COORD_W-1:0] y);
		verdict_t v;
		int       sx, sy, px, py, cx, cy, gw, gh, idx;
		v.keep   = 1'b0;
		v.status = gks_pkg::STATUS_KEPT;
		v.cell_x = '0;
		v.cell_y = '0;
		if (op == gks_pkg::OP_FRAME) begin
			cell_marked = '{default: 1'b0};
			v.status    = gks_pkg::STATUS_FRAME;
			return v;
		end
		sx = int'($signed(x));
		sy = int'($signed(y));
		px = sx / SUB_PER_PX;
		py = sy / SUB_PER_PX;
		cx = sx / SUB_PER_CELL;
		cy = sy / SUB_PER_CELL;
		gw = grid_span(cols_now);
		gh = grid_span(rows_now);
		// Outside the grid or outside the image: both bounds apply
		if (cx < 0 || cx >= gw || cy < 0 || cy >= gh ||
				px < 0 || px >= int'(cols_now) || py < 0 || py >= int'(rows_now)) begin
			v.status = gks_pkg::STATUS_OOB;
			return v;
		end
		v.cell_x = cx[gks_pkg::CELL_OUT_W-1:0];
		v.cell_y = cy[gks_pkg::CELL_OUT_W-1:0];
		idx      = cy * MAX_GRID + cx;
		if (cell_marked[idx]) begin
			v.status = gks_pkg::STATUS_OCC;
		end else begin
			cell_marked[idx] = 1'b1;
			v.keep           = 1'b1;
		end
		return v;
	endfunction

	// One input word. Valid goes up with the payload and stays until taken;
	// the caller either sends again or drains in the same time step.
	task automatic send_word(logic op, int x, int y);
		int                          gap;
		logic [gks_pkg::COORD_W-1:0] xw, yw;
		verdict_t                    v;
		xw  = x[gks_pkg::COORD_W-1:0];
		yw  = y[gks_pkg::COORD_W-1:0];
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		point_x  <= xw;
		point_y  <= yw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		v = suppress_point(op, xw, yw);
		pending_verdicts.insert(pending_verdicts.size(), v);
	endtask

	// Mostly well-formed points around the current image, so cells fill up
	// and collide; a few frame starts and some full-range noise.
	task automatic send_random_word();
		int pick, x, y;
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			send_word(gks_pkg::OP_FRAME, $urandom, $urandom);
		end else if (pick < 12) begin
			send_word(gks_pkg::OP_POINT, $urandom, $urandom);
		end else begin
			x = $urandom_range(0, cols_now * SUB_PER_PX + 80) - 40;
			y = $urandom_range(0, rows_now * SUB_PER_PX + 80) - 40;
			send_word(gks_pkg::OP_POINT, x, y);
		end
	endtask

	// Stop sending, wait for every queued result, then let the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both size registers, back to back, only with the block idle
	task automatic set_image(logic [gks_pkg::DIM_W-1:0] rows, logic [gks_pkg::DIM_W-1:0] cols);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= gks_pkg::REG_IMAGE_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_index <= gks_pkg::REG_IMAGE_COLS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_we    <= 1'b0;
		rows_now  = rows;
		cols_now  = cols;
	endtask

	// Reset sizes (grid 64 x 48): edges of the image, small negatives,
	// extremes of the coordinate range, occupancy and frame clear.
	task automatic test_directed_bounds();
		send_word(gks_pkg::OP_FRAME, 0, 0);
		send_word(gks_pkg::OP_POINT, 0, 0);
		send_word(gks_pkg::OP_POINT, 0, 0);
		send_word(gks_pkg::OP_POINT, -1, -1);
		send_word(gks_pkg::OP_POINT, -15, 200);
		send_word(gks_pkg::OP_POINT, -16, 0);
		send_word(gks_pkg::OP_POINT, 0, -160);
		send_word(gks_pkg::OP_POINT, -32768, -32768);
		send_word(gks_pkg::OP_POINT, 32767, 32767);
		send_word(gks_pkg::OP_POINT, 10239, 7679);
		send_word(gks_pkg::OP_POINT, 10240, 0);
		send_word(gks_pkg::OP_POINT, 0, 7680);
		send_word(gks_pkg::OP_POINT, 160, 0);
		send_word(gks_pkg::OP_FRAME, -1, -1);
		send_word(gks_pkg::OP_POINT, 10239, 7679);
	endtask

	// Empty grid, largest image, a grid smaller than the image
	task automatic test_register_extremes();
		set_image('0, '0);
		send_word(gks_pkg::OP_POINT, 0, 0);
		set_image('0, {gks_pkg::DIM_W{1'b1}});
		send_word(gks_pkg::OP_POINT, 100, 0);
		set_image({gks_pkg::DIM_W{1'b1}}, {gks_pkg::DIM_W{1'b1}});
		send_word(gks_pkg::OP_POINT, 32639, 32639);
		send_word(gks_pkg::OP_POINT, 32640, 0);
		send_word(gks_pkg::OP_POINT, 0, 32767);
		send_word(gks_pkg::OP_POINT, 32639, 32639);
		set_image(11'd1, 11'd1);
		send_word(gks_pkg::OP_POINT, 15, 15);
		set_image(11'd19, 11'd25);
		send_word(gks_pkg::OP_POINT, 240, 0);
		send_word(gks_pkg::OP_POINT, 0, 160);
		send_word(gks_pkg::OP_POINT, 399, 0);
	endtask

	// Small images: few cells, so occupancy dominates
	task automatic test_random_small_images();
		for (int phase = 0; phase < 8; phase++) begin
			set_image(11'($urandom_range(10, 80)), 11'($urandom_range(10, 80)));
			idle_on = (phase % 3 != 0);
			send_word(gks_pkg::OP_FRAME, 0, 0);
			repeat (150) send_random_word();
		end
	endtask

	// Reset sizes, the largest image and random large ones
	task automatic test_random_large_images();
		for (int phase = 0; phase < 4; phase++) begin
			unique case (phase)
				0: set_image(gks_pkg::IMAGE_ROWS_RST, gks_pkg::IMAGE_COLS_RST);
				1: set_image({gks_pkg::DIM_W{1'b1}}, {gks_pkg::DIM_W{1'b1}});
				default: set_image(11'($urandom_range(81, 2047)),
					11'($urandom_range(81, 2047)));
			endcase
			idle_on = (phase != 2);
			repeat (200) send_random_word();
		end
	endtask

	// Sender holds off until the result queue is empty, several times over
	task automatic test_pause_until_drained();
		idle_on = 1'b1;
		repeat (5) begin
			repeat ($urandom_range(5, 20)) send_random_word();
			drain_results();
		end
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// Result side: random ready stalls, one check per accepted result word
	initial begin
		verdict_t want;
		int       stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_on ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (pending_verdicts.size() == 0) begin
				$error("result word with nothing pending: keep %0b status %0d", keep, status);
				n_errors++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("keep", 8'(want.keep), 8'(keep));
				check_field("status", 8'(want.status), 8'(status));
				check_field("cell_x", want.cell_x, cell_x);
				check_field("cell_y", want.cell_y, cell_y);
			end
		end
	end

	// Watchdog: counts cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cyc = 0;
		else
			quiet_cyc = quiet_cyc + 1;
		if (quiet_cyc >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_bounds();
		test_register_extremes();
		test_random_small_images();
		test_random_large_images();
		test_pause_until_drained();
		drain_results();
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
